// ----- design/sosk_pkg.sv -----
// Shared types and constants for the sum_of_k_smallest block.
package sosk_pkg;

   localparam int VALUE_BITS = 10;
   localparam int SUM_BITS   = 16;
   localparam int K_BITS     = 7;

   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [SUM_BITS-1:0]   sum_type;
   typedef logic [K_BITS-1:0]     k_type;

   localparam value_type EMPTY_VALUE = '1;

   typedef struct packed {
      value_type cost;
      logic      last;
   } req_word_type;

   typedef struct packed {
      sum_type total;
      logic    short_set;
   } rsp_word_type;

   // Broadcast control from the top level to every cell.
   typedef struct packed {
      logic clear;
      logic insert;
      logic replace;
   } cell_ctrl_type;

endpackage

// ----- design/sosk_cell.sv -----
// One slot of the sorted insertion chain.
module sosk_cell import sosk_pkg::*; #(
   parameter int IDX = 0,
   parameter int CW  = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic [CW-1:0] count,
   input  value_type     new_value,
   input  value_type     left_value,
   input  logic          left_gt,
   output value_type     value,
   output logic          gt,
   output value_type     top_value,
   output logic          top_gt
);

   localparam logic [CW-1:0] IDX_C  = CW'(IDX);
   localparam logic [CW-1:0] IDX_P1 = CW'(IDX + 1);

   value_type value_ff;
   value_type value_in;
   logic      below;
   logic      at_end;
   logic      is_top;
   logic      update;

   assign below  = IDX_C < count;
   assign at_end = IDX_C == count;
   assign is_top = IDX_P1 == count;
   assign gt     = value_ff > new_value;
   assign update = ctrl.insert ? (below | at_end) : (ctrl.replace & below);

   always_comb begin
      value_in = value_ff;
      if (ctrl.clear) begin
         value_in = EMPTY_VALUE;
      end else if (update) begin
         if (left_gt) begin
            value_in = left_value;
         end else if (gt) begin
            value_in = new_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= EMPTY_VALUE;
      end else begin
         value_ff <= value_in;
      end
   end

   assign value     = value_ff;
   assign top_value = is_top ? value_ff : '0;
   assign top_gt    = is_top & gt;

endmodule

// ----- design/sum_of_k_smallest.sv -----
// Top level: sum of the k smallest values of a set, kept in a sorted cell chain.
// The result word is registered, valid in the cycle after a set's last word is taken.
// Throughput: one input word per cycle; each word updates the affected cells together.
// Any input word waits while a previous result is still held and not taken.
// Reset: store slots go to all ones, count and sum to zero, k_count to 1.
module sum_of_k_smallest import sosk_pkg::*; #(
   parameter int MAX_K = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data,
   input  logic         csr_we,
   input  k_type        csr_wdata
);

   localparam int CW = $clog2(MAX_K + 1);
   localparam int KW = (CW > K_BITS) ? CW : K_BITS;
   localparam logic [KW-1:0] MAX_K_W = KW'(MAX_K);

   k_type         k_count_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   sum_type       sum_ff;
   sum_type       sum_in;
   sum_type       sum_upd;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   rsp_word_type  rsp_data_ff;
   rsp_word_type  rsp_data_in;

   logic          fire;
   logic [KW-1:0] k_wide;
   logic [KW-1:0] k_eff;
   logic [KW-1:0] n_wide;
   logic [KW-1:0] n_upd_wide;
   logic [CW-1:0] count_upd;
   cell_ctrl_type ctrl;
   value_type     drop_value;
   logic          drop_gt;

   value_type     cell_value [MAX_K];
   logic          cell_gt    [MAX_K];
   value_type     cell_top   [MAX_K];
   logic          cell_tgt   [MAX_K];

   assign fire      = req_valid & req_ready;
   assign req_ready = ~rsp_valid_ff | rsp_ready;

   assign k_wide = KW'(k_count_ff);
   assign k_eff  = (k_wide > MAX_K_W) ? MAX_K_W : k_wide;
   assign n_wide = KW'(count_ff);

   always_comb begin
      drop_value = '0;
      drop_gt    = 1'b0;
      for (int i = 0; i < MAX_K; i++) begin
         drop_value = drop_value | cell_top[i];
         drop_gt    = drop_gt | cell_tgt[i];
      end
   end

   always_comb begin
      ctrl.insert  = fire & (k_eff != '0) & (n_wide < k_eff);
      ctrl.replace = fire & (k_eff != '0) & (n_wide >= k_eff) & drop_gt;
      ctrl.clear   = fire & req_data.last;
   end

   always_comb begin
      count_upd = count_ff;
      sum_upd   = sum_ff;
      if (ctrl.insert) begin
         count_upd = count_ff + CW'(1);
         sum_upd   = sum_ff + SUM_BITS'(req_data.cost);
      end else if (ctrl.replace) begin
         sum_upd = sum_ff - SUM_BITS'(drop_value) + SUM_BITS'(req_data.cost);
      end
      n_upd_wide = KW'(count_upd);
      count_in   = ctrl.clear ? '0 : count_upd;
      sum_in     = ctrl.clear ? '0 : sum_upd;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (ctrl.clear) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.total     = sum_upd;
         rsp_data_in.short_set = n_upd_wide < k_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_count_ff   <= K_BITS'(1);
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            k_count_ff <= csr_wdata;
         end
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   for (genvar g = 0; g < MAX_K; g++) begin : g_cell
      value_type left_value;
      logic      left_gt;

      if (g == 0) begin : g_first
         assign left_value = EMPTY_VALUE;
         assign left_gt    = 1'b0;
      end else begin : g_rest
         assign left_value = cell_value[g-1];
         assign left_gt    = cell_gt[g-1];
      end

      sosk_cell #(
         .IDX (g),
         .CW  (CW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .count      (count_ff),
         .new_value  (req_data.cost),
         .left_value (left_value),
         .left_gt    (left_gt),
         .value      (cell_value[g]),
         .gt         (cell_gt[g]),
         .top_value  (cell_top[g]),
         .top_gt     (cell_tgt[g])
      );
   end

endmodule
